// File: hdl/vife_pkg.sv
// Package: shared types and constants for the VLAN/IPv4 flow field extractor.
`timescale 1ns / 1ps

package vife_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 16384;

    localparam logic [2:0] PH_TYPE      = 3'd0;
    localparam logic [2:0] PH_IP        = 3'd1;
    localparam logic [2:0] PH_TRANSPORT = 3'd2;
    localparam logic [2:0] PH_DONE      = 3'd3;
    localparam logic [2:0] PH_SKIP      = 3'd4;

    localparam logic [15:0] ETHERTYPE_TAG  = 16'h8100;
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;
    localparam logic [3:0]  IHL_MASK       = 4'hF;
    localparam logic [7:0]  BYTE_MASK      = 8'hFF;
    localparam logic [3:0]  IHL_MIN        = 4'd5;
    localparam int          ETH_TYPE_END   = 14;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_end;
    } vife_in_t;

    typedef struct packed {
        logic [31:0] source_address;
        logic [31:0] destination_address;
        logic [15:0] ip_total_length;
        logic [7:0]  ip_protocol;
        logic [15:0] source_port;
        logic [15:0] destination_port;
        logic        ports_valid;
    } vife_out_t;

endpackage

// File: hdl/vife_parser.sv
// Byte parser: header walk state and field capture, one byte per step.
`timescale 1ns / 1ps

module vife_parser #(
    parameter int MAX_FRAME_BYTES = vife_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  vife_pkg::vife_in_t  item,
    output logic                result_valid,
    output vife_pkg::vife_out_t result
);

    localparam int POS_W = $clog2(MAX_FRAME_BYTES + 4);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_FRAME_BYTES);
    localparam logic [POS_W-1:0] IP_START_RST = POS_W'(vife_pkg::ETH_TYPE_END);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [2:0]       phase_reg, phase_next;
    logic [15:0]      type_reg, type_next;
    logic [POS_W-1:0] ip_start_reg, ip_start_next;
    logic [3:0]       hw_reg, hw_next;
    logic [15:0]      len_reg, len_next;
    logic [7:0]       proto_reg, proto_next;
    logic [31:0]      src_reg, src_next;
    logic [31:0]      dst_reg, dst_next;
    logic [31:0]      ports_reg, ports_next;
    logic [2:0]       pbytes_reg, pbytes_next;

    logic [POS_W-1:0] off;
    logic [7:0]       b;
    logic             port_proto;
    logic             pv;

    assign b   = item.data_byte & vife_pkg::BYTE_MASK;
    assign off = pos_reg - ip_start_reg;

    always_comb
    begin
        pos_next      = pos_reg;
        phase_next    = phase_reg;
        type_next     = type_reg;
        ip_start_next = ip_start_reg;
        hw_next       = hw_reg;
        len_next      = len_reg;
        proto_next    = proto_reg;
        src_next      = src_reg;
        dst_next      = dst_reg;
        ports_next    = ports_reg;
        pbytes_next   = pbytes_reg;

        if (pos_reg < POS_MAX)
        begin
            pos_next = pos_reg + POS_W'(1);
            unique case (phase_reg)
                vife_pkg::PH_TYPE:
                begin
                    if ((pos_reg + POS_W'(2) == ip_start_reg) ||
                        (pos_reg + POS_W'(1) == ip_start_reg))
                    begin
                        type_next = {type_reg[7:0], b};
                    end
                    if (pos_reg + POS_W'(1) == ip_start_reg)
                    begin
                        if (type_next == vife_pkg::ETHERTYPE_TAG)
                            ip_start_next = ip_start_reg + POS_W'(4);
                        else if (type_next == vife_pkg::ETHERTYPE_IPV4)
                            phase_next = vife_pkg::PH_IP;
                        else
                            phase_next = vife_pkg::PH_SKIP;
                    end
                end
                vife_pkg::PH_IP:
                begin
                    if (off == '0)
                    begin
                        hw_next = b[3:0] & vife_pkg::IHL_MASK;
                        if (hw_next < vife_pkg::IHL_MIN)
                            phase_next = vife_pkg::PH_SKIP;
                    end
                    else
                    begin
                        if (off == POS_W'(2) || off == POS_W'(3))
                            len_next = {len_reg[7:0], b};
                        else if (off == POS_W'(9))
                            proto_next = b;
                        else if (off >= POS_W'(12) && off <= POS_W'(15))
                            src_next[{off[1:0], 3'b000} +: 8] = b;
                        else if (off >= POS_W'(16) && off <= POS_W'(19))
                            dst_next[{off[1:0], 3'b000} +: 8] = b;
                        if (off + POS_W'(1) == POS_W'({hw_reg, 2'b00}))
                        begin
                            if (proto_next == vife_pkg::PROTO_TCP ||
                                proto_next == vife_pkg::PROTO_UDP)
                                phase_next = vife_pkg::PH_TRANSPORT;
                            else
                                phase_next = vife_pkg::PH_DONE;
                        end
                    end
                end
                vife_pkg::PH_TRANSPORT:
                begin
                    ports_next  = {ports_reg[23:0], b};
                    pbytes_next = pbytes_reg + 3'd1;
                    if (pbytes_next >= 3'd4)
                        phase_next = vife_pkg::PH_DONE;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign port_proto = (proto_next == vife_pkg::PROTO_TCP) ||
                        (proto_next == vife_pkg::PROTO_UDP);
    assign pv = port_proto && (pbytes_next >= 3'd4);

    assign result_valid = item.frame_end &&
                          ((phase_next == vife_pkg::PH_TRANSPORT) ||
                           (phase_next == vife_pkg::PH_DONE));

    always_comb
    begin
        result.source_address      = src_next;
        result.destination_address = dst_next;
        result.ip_total_length     = len_next;
        result.ip_protocol         = proto_next;
        result.source_port         = pv ? ports_next[31:16] : 16'd0;
        result.destination_port    = pv ? ports_next[15:0] : 16'd0;
        result.ports_valid         = pv;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            phase_reg    <= vife_pkg::PH_TYPE;
            type_reg     <= '0;
            ip_start_reg <= IP_START_RST;
            hw_reg       <= '0;
            len_reg      <= '0;
            proto_reg    <= '0;
            src_reg      <= '0;
            dst_reg      <= '0;
            ports_reg    <= '0;
            pbytes_reg   <= '0;
        end
        else if (step)
        begin
            if (item.frame_end)
            begin
                pos_reg      <= '0;
                phase_reg    <= vife_pkg::PH_TYPE;
                type_reg     <= '0;
                ip_start_reg <= IP_START_RST;
                hw_reg       <= '0;
                len_reg      <= '0;
                proto_reg    <= '0;
                src_reg      <= '0;
                dst_reg      <= '0;
                ports_reg    <= '0;
                pbytes_reg   <= '0;
            end
            else
            begin
                pos_reg      <= pos_next;
                phase_reg    <= phase_next;
                type_reg     <= type_next;
                ip_start_reg <= ip_start_next;
                hw_reg       <= hw_next;
                len_reg      <= len_next;
                proto_reg    <= proto_next;
                src_reg      <= src_next;
                dst_reg      <= dst_next;
                ports_reg    <= ports_next;
                pbytes_reg   <= pbytes_next;
            end
        end
    end

endmodule

// File: hdl/vlan_ipv4_flow_field_extractor_top.sv
// Top level: input register, byte parser and result register.
`timescale 1ns / 1ps

// Takes one Ethernet frame byte per cycle with a last-byte mark, skips stacked
// VLAN tags, and for IPv4 frames whose header arrived complete emits one item
// holding addresses, total length, protocol and TCP/UDP ports; other frames
// give nothing. Sustained rate is one byte per cycle. A byte passes through an
// input register, and the parser loads the result register from it when the
// frame's last byte is stepped through the parser.
// Only a last byte waits on a full result register; other bytes keep flowing.
module vlan_ipv4_flow_field_extractor_top #(
    parameter int MAX_FRAME_BYTES = vife_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  vife_pkg::vife_in_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output vife_pkg::vife_out_t out_data
);

    logic                s1_valid_reg;
    vife_pkg::vife_in_t  s1_item_reg;
    logic                out_valid_reg;
    vife_pkg::vife_out_t out_data_reg;

    logic                out_free;
    logic                step;
    logic                res_valid;
    vife_pkg::vife_out_t res;

    assign out_free = !out_valid_reg || out_ready;
    assign step     = s1_valid_reg && (!s1_item_reg.frame_end || out_free);
    assign in_ready = !s1_valid_reg || step;

    vife_parser #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .item        (s1_item_reg),
        .result_valid(res_valid),
        .result      (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            s1_item_reg <= in_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step && res_valid)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step && res_valid)
            out_data_reg <= res;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
